@@ rtl/core/krt_pkg.sv @@
// Package: shared types, constants and codes of the keyed record table.
`default_nettype none

package krt_pkg;

  localparam int unsigned CAPACITY = 8;
  localparam int unsigned PosW     = $clog2(CAPACITY);
  localparam int unsigned CntW     = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW     = 3;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_RANGE     = 2'd3
  } status_e;

  typedef struct packed {
    logic [63:0] name_low;
    logic [15:0] name_high;
    logic [63:0] phone_low;
    logic [23:0] phone_high;
    logic [63:0] address_word0;
    logic [63:0] address_word1;
    logic [63:0] address_word2;
    logic [47:0] address_word3;
    logic [31:0] birth_date;
  } rec_t;

  typedef struct packed {
    op_e         operation;
    logic [2:0]  index;
    logic [63:0] name_low;
    logic [15:0] name_high;
    logic [63:0] phone_low;
    logic [23:0] phone_high;
    logic [63:0] address_word0;
    logic [63:0] address_word1;
    logic [63:0] address_word2;
    logic [47:0] address_word3;
    logic [31:0] birth_date;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [2:0]  found_index;
    logic [3:0]  entry_total;
    logic [63:0] out_name_low;
    logic [15:0] out_name_high;
    logic [63:0] out_phone_low;
    logic [23:0] out_phone_high;
    logic [63:0] out_address_word0;
    logic [63:0] out_address_word1;
    logic [63:0] out_address_word2;
    logic [47:0] out_address_word3;
    logic [31:0] out_birth_date;
  } rsp_t;

  // Search word walking the cell chain.
  typedef struct packed {
    logic            valid;
    logic            found;
    logic [PosW-1:0] pos;
    rec_t            rec;
  } probe_t;

  // Operation context shared by all cells.
  typedef struct packed {
    op_e             op;
    logic [63:0]     key_low;
    logic [15:0]     key_high;
    logic [IdxW-1:0] index;
    logic [CntW-1:0] count;
    logic            ins_we;
    rec_t            ins_rec;
  } scan_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/krt_if.sv @@
// Interfaces: request and response channels of the keyed record table.
`default_nettype none

interface krt_req_if;
  import krt_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
  modport mon (input valid, input ready, input data);
endinterface

interface krt_rsp_if;
  import krt_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
  modport mon (input valid, input ready, input data);
endinterface

`default_nettype wire

@@ rtl/core/krt_cell.sv @@
// Cell: one stored record plus one stage of the search chain.
`default_nettype none

module krt_cell (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire  [krt_pkg::CntW-1:0]   pos_i,
  input  wire krt_pkg::scan_ctrl_t   ctrl_i,
  input  wire krt_pkg::probe_t       probe_i,
  input  wire krt_pkg::rec_t         rec_next_i,
  output krt_pkg::probe_t            probe_o,
  output krt_pkg::rec_t              rec_o
);
  import krt_pkg::*;

  rec_t   rec_q, rec_d;
  probe_t probe_q, probe_d;
  logic   in_range;
  logic   key_hit;
  logic   shift;

  assign in_range = pos_i < ctrl_i.count;
  assign key_hit  = (rec_q.name_low == ctrl_i.key_low) && (rec_q.name_high == ctrl_i.key_high);

  always_comb begin
    probe_d = probe_i;
    shift   = 1'b0;
    if (probe_i.valid && in_range) begin
      unique case (ctrl_i.op)
        OP_SEARCH: begin
          if (key_hit) begin
            probe_d.found = 1'b1;
            probe_d.pos   = PosW'(pos_i);
            probe_d.rec   = rec_q;
          end
        end
        OP_DELETE: begin
          if (probe_i.found) begin
            shift = 1'b1;
          end else if (key_hit) begin
            probe_d.found = 1'b1;
            probe_d.pos   = PosW'(pos_i);
            probe_d.rec   = rec_q;
            shift         = 1'b1;
          end
        end
        OP_READ: begin
          if (pos_i == CntW'(ctrl_i.index)) begin
            probe_d.found = 1'b1;
            probe_d.pos   = PosW'(pos_i);
            probe_d.rec   = rec_q;
          end
        end
        OP_INSERT: begin
        end
      endcase
    end
  end

  always_comb begin
    rec_d = rec_q;
    if (ctrl_i.ins_we && (pos_i == ctrl_i.count)) begin
      rec_d = ctrl_i.ins_rec;
    end else if (shift) begin
      rec_d = rec_next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else begin
      probe_q <= probe_d;
    end
  end

  assign probe_o = probe_q;
  assign rec_o   = rec_q;

endmodule

`default_nettype wire

@@ rtl/core/krt_ctrl.sv @@
// Controller: request intake, entry count, probe launch and response register.
`default_nettype none

module krt_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  krt_req_if.sink             req_i,
  krt_rsp_if.source           rsp_o,
  output krt_pkg::scan_ctrl_t ctrl_o,
  output krt_pkg::probe_t     probe_o,
  input  wire krt_pkg::probe_t probe_i
);
  import krt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            launch_q;
  op_e             op_q;
  logic [63:0]     key_low_q;
  logic [15:0]     key_high_q;
  logic [IdxW-1:0] index_q;
  rsp_t            res_q, res_d;
  rsp_t            out_q;
  logic            out_valid_q, out_valid_d;
  logic            accept;
  logic            is_insert;
  logic            full;
  logic            out_free;
  logic            load_res;
  rec_t            in_rec;

  function automatic rsp_t make_rsp(status_e st, logic [IdxW-1:0] idx,
                                    logic [CntW-1:0] total, rec_t r);
    rsp_t v;
    v.status            = st;
    v.found_index       = idx;
    v.entry_total       = total;
    v.out_name_low      = r.name_low;
    v.out_name_high     = r.name_high;
    v.out_phone_low     = r.phone_low;
    v.out_phone_high    = r.phone_high;
    v.out_address_word0 = r.address_word0;
    v.out_address_word1 = r.address_word1;
    v.out_address_word2 = r.address_word2;
    v.out_address_word3 = r.address_word3;
    v.out_birth_date    = r.birth_date;
    return v;
  endfunction

  assign in_rec.name_low      = req_i.data.name_low;
  assign in_rec.name_high     = req_i.data.name_high;
  assign in_rec.phone_low     = req_i.data.phone_low;
  assign in_rec.phone_high    = req_i.data.phone_high;
  assign in_rec.address_word0 = req_i.data.address_word0;
  assign in_rec.address_word1 = req_i.data.address_word1;
  assign in_rec.address_word2 = req_i.data.address_word2;
  assign in_rec.address_word3 = req_i.data.address_word3;
  assign in_rec.birth_date    = req_i.data.birth_date;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign is_insert   = (req_i.data.operation == OP_INSERT);
  assign full        = (count_q >= CntW'(CAPACITY));
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign load_res    = (state_q == S_DONE) && out_free;

  assign ctrl_o.op       = op_q;
  assign ctrl_o.key_low  = key_low_q;
  assign ctrl_o.key_high = key_high_q;
  assign ctrl_o.index    = index_q;
  assign ctrl_o.count    = count_q;
  assign ctrl_o.ins_we   = accept && is_insert && !full;
  assign ctrl_o.ins_rec  = in_rec;

  assign probe_o.valid = launch_q;
  assign probe_o.found = 1'b0;
  assign probe_o.pos   = '0;
  assign probe_o.rec   = '0;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    res_d   = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (is_insert) begin
            if (full) begin
              res_d = make_rsp(STAT_FULL, '0, count_q, '0);
            end else begin
              res_d   = make_rsp(STAT_OK, IdxW'(count_q), count_q + CntW'(1), in_rec);
              count_d = count_q + CntW'(1);
            end
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (probe_i.valid) begin
          unique case (op_q)
            OP_SEARCH: begin
              res_d = make_rsp(probe_i.found ? STAT_OK : STAT_NOT_FOUND,
                               IdxW'(probe_i.pos), count_q, probe_i.rec);
            end
            OP_DELETE: begin
              res_d = make_rsp(probe_i.found ? STAT_OK : STAT_NOT_FOUND,
                               IdxW'(probe_i.pos),
                               count_q - CntW'(probe_i.found), probe_i.rec);
              count_d = count_q - CntW'(probe_i.found);
            end
            OP_READ: begin
              res_d = make_rsp(probe_i.found ? STAT_OK : STAT_RANGE,
                               IdxW'(probe_i.pos), count_q, probe_i.rec);
            end
            OP_INSERT: begin
              res_d = make_rsp(STAT_OK, '0, count_q, '0);
            end
          endcase
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_o.valid && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load_res) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      launch_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      launch_q    <= accept && !is_insert;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= req_i.data.operation;
      key_low_q  <= req_i.data.name_low;
      key_high_q <= req_i.data.name_high;
      index_q    <= req_i.data.index;
    end
    res_q <= res_d;
    if (load_res) begin
      out_q <= res_q;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

endmodule

`default_nettype wire

@@ rtl/core/keyed_record_table.sv @@
// Top level: keyed record table built from a chain of record cells.
`default_nettype none

// A table of up to CAPACITY records (10-byte name key, phone, address,
// birthday), one record per cell. Insert writes the cell at the current fill
// level. Search, delete and read send a probe word down the cell chain, one
// cell per cycle. Each result passes through a result register into the
// output register, and a new request is taken only after that. Search
// reports the last matching entry, delete the first and compacts the later
// entries down one place as the probe passes them. A finished response waits
// in an output register while the next request is accepted.

module keyed_record_table (
  input  wire       clk_i,
  input  wire       rst_ni,
  krt_req_if.sink   req_i,
  krt_rsp_if.source rsp_o
);
  import krt_pkg::*;

  scan_ctrl_t ctrl;
  probe_t     chain [CAPACITY+1];
  rec_t       cell_rec [CAPACITY+1];

  krt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .rsp_o   (rsp_o),
    .ctrl_o  (ctrl),
    .probe_o (chain[0]),
    .probe_i (chain[CAPACITY])
  );

  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    krt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .pos_i      (CntW'(j)),
      .ctrl_i     (ctrl),
      .probe_i    (chain[j]),
      .rec_next_i (cell_rec[j+1]),
      .probe_o    (chain[j+1]),
      .rec_o      (cell_rec[j])
    );
  end

  assign cell_rec[CAPACITY] = cell_rec[CAPACITY-1];

endmodule

`default_nettype wire

@@ rtl/core/krt_checker.sv @@
// Checker: port-level properties of the keyed record table, bound to the top.
`default_nettype none

module krt_checker (
  input wire        clk_i,
  input wire        rst_ni,
  krt_req_if.sink   req_i,
  krt_rsp_if.source rsp_o
);
  import krt_pkg::*;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |=> rsp_o.valid && $stable(rsp_o.data))
    else $error("response word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request taken while previous one in flight");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> rsp_o.data.entry_total <= 4'(CAPACITY))
    else $error("entry total above capacity");

  a_full_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.data.status == STAT_FULL)
      |-> rsp_o.data.entry_total == 4'(CAPACITY))
    else $error("table full reported below capacity");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.data.status != STAT_OK)
      |-> (rsp_o.data.found_index == '0) && (rsp_o.data.out_name_low == '0)
          && (rsp_o.data.out_birth_date == '0))
    else $error("failed operation returned record data");

endmodule

bind keyed_record_table krt_checker u_krt_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .req_i  (req_i),
  .rsp_o  (rsp_o)
);

`default_nettype wire
